/* rtl/core/delayed_flash_envelope_top_defines.svh */
// Assertion macros for the delayed flash envelope block.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef DELAYED_FLASH_ENVELOPE_TOP_DEFINES_SVH
`define DELAYED_FLASH_ENVELOPE_TOP_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/dfe_pkg.sv */
// Shared constants and helper functions for the delayed flash envelope.
// No dependencies.
package dfe_pkg;

  localparam int unsigned COS_TABLE_BITS = 10;

  // Configuration register indexes
  localparam logic [2:0] REG_START_DELAY  = 3'd0;
  localparam logic [2:0] REG_FLASH_LENGTH = 3'd1;
  localparam logic [2:0] REG_EASE_MODE    = 3'd2;
  localparam logic [2:0] REG_PEAK_GAIN    = 3'd3;
  localparam logic [2:0] REG_HUE_RED      = 3'd4;
  localparam logic [2:0] REG_HUE_GREEN    = 3'd5;
  localparam logic [2:0] REG_HUE_BLUE     = 3'd6;

  // Ease mode codes; anything else is linear
  localparam logic [1:0] EASE_SQUARE = 2'd1;
  localparam logic [1:0] EASE_CUBE   = 2'd2;

  localparam int unsigned DIV_STEPS = 16;
  localparam logic [16:0] PHASE_ONE = 17'h10000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // sin^2(pi*q/65536) in Q1.16, q in [0, 32768]; fixed Q2.30 Taylor series.
  // Evaluated at elaboration only.
  function automatic logic [16:0] raised_level(input logic [31:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] f;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(q) * PI_Q30) >> 16;
    x2 = (x * x) >> 30;
    f  = Q30_ONE;
    f  = Q30_ONE - ((x2 * f) >> 30) / 64'd110;
    f  = Q30_ONE - ((x2 * f) >> 30) / 64'd72;
    f  = Q30_ONE - ((x2 * f) >> 30) / 64'd42;
    f  = Q30_ONE - ((x2 * f) >> 30) / 64'd20;
    f  = Q30_ONE - ((x2 * f) >> 30) / 64'd6;
    s  = (x * f) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    r = (s * s + (64'd1 << 43)) >> 44;
    return r[16:0];
  endfunction

  // Channel product is Q8.8 * Q1.16 * Q0.16; drop 24 bits and clamp to 16.
  function automatic logic [15:0] sat_channel(input logic [48:0] p);
    return (p[48:40] != 9'd0) ? 16'hFFFF : p[39:24];
  endfunction

endpackage

/* rtl/core/delayed_flash_envelope_top.sv */
// Delayed flash envelope: tick-driven one-shot light flash, colour output.
// Depends on dfe_pkg and delayed_flash_envelope_top_defines.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  tick    | in        | in_valid_i/in_stall_o | tick_delta_i[15:0]
//  colour  | out       | out_valid_o/out_stall_i| out_red/green/blue_o, color_changed_o
//  config  | in        | cfg_we_i (no wait)    | cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
// One tick is in flight at a time. A colour tick loads its result after the
// 16-step serial phase divider, which is skipped when the phase is one, and the
// easing, gain and colour steps; ticks before the delay or after the end free
// the input again without a result.
// One 32x17 multiplier is shared by easing, gain and the three colour scales.
// Reset clears the accumulators, configuration, sequencer state and last colour.
// A stalled output holds the sequencer in its final step; the result register
// frees as soon as the colour transaction completes.
`include "delayed_flash_envelope_top_defines.svh"

module delayed_flash_envelope_top #(
  parameter int unsigned CosTableBits = dfe_pkg::COS_TABLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] tick_delta_i,
  // colour channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic        color_changed_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned TblSize   = 1 << CosTableBits;
  localparam int unsigned IdxShift  = 16 - CosTableBits;
  localparam int unsigned CntW      = $clog2(dfe_pkg::DIV_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(dfe_pkg::DIV_STEPS - 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_ACC    = 14'b00000000000010,
    S_GATE   = 14'b00000000000100,
    S_PHASE  = 14'b00000000001000,
    S_DIV    = 14'b00000000010000,
    S_EASE_A = 14'b00000000100000,
    S_EASE_B = 14'b00000001000000,
    S_EASE_C = 14'b00000010000000,
    S_LOOKUP = 14'b00000100000000,
    S_GAIN   = 14'b00001000000000,
    S_RED    = 14'b00010000000000,
    S_GREEN  = 14'b00100000000000,
    S_BLUE   = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_e;

  // ---------------------------------------------------------------------------
  // Level table: raised cosine (1 - cos 2 pi t)/2, folded about t = 0.5.
  // Constant logic built at elaboration.
  // ---------------------------------------------------------------------------
  logic [16:0] lvl_tbl [TblSize];

  for (genvar gi = 0; gi < TblSize; gi++) begin : g_lvl
    localparam int unsigned P = gi << IdxShift;
    localparam int unsigned Q = (P <= 32768) ? P : 65536 - P;
    assign lvl_tbl[gi] = dfe_pkg::raised_level(32'(Q));
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e      state_q, state_d;

  logic [31:0] start_delay_q, flash_length_q;
  logic [1:0]  ease_mode_q;
  logic [15:0] peak_gain_q, hue_red_q, hue_green_q, hue_blue_q;

  logic [32:0] total_q, total_d;   // saturating total time
  logic [32:0] flash_q, flash_d;   // saturating playback time
  logic [15:0] delta_q;

  logic [16:0] t_q, t_d;           // phase, Q1.16
  logic [16:0] u_q, u_d;           // 1 - phase
  logic [31:0] rem_q, rem_d;       // divider remainder
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [16:0] level_q;
  logic [31:0] gl_q, gl_d;         // peak_gain * level
  logic [15:0] red_q, red_d, green_q, green_d;

  logic [48:0] prod_q;
  logic        mul_en;
  logic [31:0] mul_a;
  logic [16:0] mul_b;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_red_q, out_green_q, out_blue_q;
  logic        changed_q;
  logic        out_load;
  logic [15:0] blue_now;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q  <= '0;
      flash_length_q <= '0;
      ease_mode_q    <= '0;
      peak_gain_q    <= '0;
      hue_red_q      <= '0;
      hue_green_q    <= '0;
      hue_blue_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfe_pkg::REG_START_DELAY:  start_delay_q  <= cfg_wdata_i;
        dfe_pkg::REG_FLASH_LENGTH: flash_length_q <= cfg_wdata_i;
        dfe_pkg::REG_EASE_MODE:    ease_mode_q    <= cfg_wdata_i[1:0];
        dfe_pkg::REG_PEAK_GAIN:    peak_gain_q    <= cfg_wdata_i[15:0];
        dfe_pkg::REG_HUE_RED:      hue_red_q      <= cfg_wdata_i[15:0];
        dfe_pkg::REG_HUE_GREEN:    hue_green_q    <= cfg_wdata_i[15:0];
        dfe_pkg::REG_HUE_BLUE:     hue_blue_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier, product registered
  // ---------------------------------------------------------------------------
  logic [16:0] u_now;
  assign u_now = dfe_pkg::PHASE_ONE - t_q;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_EASE_A: begin
        mul_en = 1'b1;
        mul_a  = 32'(u_now);
        mul_b  = u_now;
      end
      S_EASE_B: begin
        mul_en = 1'b1;
        mul_a  = 32'(prod_q[32:16]);
        mul_b  = u_q;
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = 32'(peak_gain_q);
        mul_b  = level_q;
      end
      S_RED: begin
        mul_en = 1'b1;
        mul_a  = prod_q[31:0];
        mul_b  = 17'(hue_red_q);
      end
      S_GREEN: begin
        mul_en = 1'b1;
        mul_a  = gl_q;
        mul_b  = 17'(hue_green_q);
      end
      S_BLUE: begin
        mul_en = 1'b1;
        mul_a  = gl_q;
        mul_b  = 17'(hue_blue_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= 49'(mul_a) * 49'(mul_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [33:0] total_sum, flash_sum;
  logic [32:0] end_time;
  logic [32:0] rem_sh;
  logic        div_ge;

  assign total_sum = {1'b0, total_q} + 34'(delta_q);
  assign flash_sum = {1'b0, flash_q} + 34'(delta_q);
  assign end_time  = {1'b0, start_delay_q} + {1'b0, flash_length_q};
  assign rem_sh    = {rem_q, 1'b0};
  assign div_ge    = rem_sh >= {1'b0, flash_length_q};
  assign blue_now  = dfe_pkg::sat_channel(prod_q);
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    flash_d = flash_q;
    t_d     = t_q;
    u_d     = u_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    gl_d    = gl_q;
    red_d   = red_q;
    green_d = green_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        // stop test looks at the total before this tick is added
        if (total_q > end_time) begin
          state_d = S_IDLE;
        end else begin
          total_d = total_sum[33] ? '1 : total_sum[32:0];
          state_d = S_GATE;
        end
      end
      S_GATE: begin
        if (total_q < {1'b0, start_delay_q}) begin
          state_d = S_IDLE;
        end else begin
          flash_d = flash_sum[33] ? '1 : flash_sum[32:0];
          state_d = S_PHASE;
        end
      end
      S_PHASE: begin
        if (flash_length_q == '0 || flash_q >= {1'b0, flash_length_q}) begin
          t_d     = dfe_pkg::PHASE_ONE;
          state_d = S_EASE_A;
        end else begin
          rem_d   = flash_q[31:0];
          t_d     = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_d = div_ge ? 32'(rem_sh - {1'b0, flash_length_q}) : rem_sh[31:0];
        t_d   = {t_q[15:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_EASE_A;
        end
      end
      S_EASE_A: begin
        u_d = u_now;
        if (ease_mode_q == dfe_pkg::EASE_SQUARE || ease_mode_q == dfe_pkg::EASE_CUBE) begin
          state_d = S_EASE_B;
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_EASE_B: begin
        if (ease_mode_q == dfe_pkg::EASE_SQUARE) begin
          t_d     = prod_q[32:16];
          state_d = S_LOOKUP;
        end else begin
          state_d = S_EASE_C;
        end
      end
      S_EASE_C: begin
        t_d     = prod_q[32:16];
        state_d = S_LOOKUP;
      end
      S_LOOKUP: state_d = S_GAIN;
      S_GAIN:   state_d = S_RED;
      S_RED: begin
        gl_d    = prod_q[31:0];
        state_d = S_GREEN;
      end
      S_GREEN: begin
        red_d   = dfe_pkg::sat_channel(prod_q);
        state_d = S_BLUE;
      end
      S_BLUE: begin
        green_d = dfe_pkg::sat_channel(prod_q);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      flash_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      flash_q <= flash_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      delta_q <= tick_delta_i;
    end
    if (state_q == S_LOOKUP) begin
      level_q <= lvl_tbl[t_q[15 -: CosTableBits]];
    end
    t_q     <= t_d;
    u_q     <= u_d;
    rem_q   <= rem_d;
    gl_q    <= gl_d;
    red_q   <= red_d;
    green_q <= green_d;
  end

  // ---------------------------------------------------------------------------
  // Result register; its colour doubles as the last emitted colour
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_red_q   <= '0;
      out_green_q <= '0;
      out_blue_q  <= '0;
      changed_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_red_q   <= red_q;
        out_green_q <= green_q;
        out_blue_q  <= blue_now;
        changed_q   <= (red_q != out_red_q) || (green_q != out_green_q) ||
                       (blue_now != out_blue_q);
      end
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_red_q;
  assign out_green_o     = out_green_q;
  assign out_blue_o      = out_blue_q;
  assign color_changed_o = changed_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DFE_ASSERT(a_accept_starts, (in_valid_i && !in_stall_o) |=> (state_q == S_ACC), "tick transaction did not start sequencer")
  `DFE_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result appeared outside final step")
  `DFE_ASSERT_ALWAYS(a_flash_le_total, flash_q <= total_q, "playback time exceeds total time")
  `DFE_ASSERT(a_div_rem_bound, (state_q == S_DIV) |-> (rem_q < flash_length_q), "divider remainder out of range")

endmodule
